@@ rtl/fnpll_pkg.sv @@
// Shared constants, tables and types for the fractional-N PLL setting calculator.
`default_nettype none
package fnpll_pkg;

    localparam int FRAC_BITS  = 18;
    localparam int TARGET_W   = 22;
    localparam int XTAL_W     = 16;
    localparam int LIMIT_W    = 22;
    localparam int CFG_DATA_W = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int VCO_W      = TARGET_W + 4;
    localparam int SCALED_W   = VCO_W + 1;
    localparam int QUO_W      = SCALED_W + FRAC_BITS;
    localparam int DIV_STEP   = 8;
    localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIVD_W     = DIV_STAGES * DIV_STEP;
    localparam int REM_W      = XTAL_W + 1;
    localparam int NINT_W     = 9;
    localparam int NFRAC_W    = 18;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_XTAL_KHZ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DOUBLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_16   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_8    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_4    = 3'd4;

    localparam logic [XTAL_W-1:0]  XTAL_RESET     = 16'd30000;
    localparam logic               DOUBLER_RESET  = 1'b1;
    localparam logic [LIMIT_W-1:0] LIMIT_16_RESET = 22'd299000;
    localparam logic [LIMIT_W-1:0] LIMIT_8_RESET  = 22'd596000;
    localparam logic [LIMIT_W-1:0] LIMIT_4_RESET  = 22'd1191000;

    // Post-divider codes
    localparam logic [1:0] PDIV_P16 = 2'd3;
    localparam logic [1:0] PDIV_P8  = 2'd2;
    localparam logic [1:0] PDIV_P4  = 2'd1;
    localparam logic [1:0] PDIV_P2  = 2'd0;

    localparam logic [NINT_W-1:0] N_ZERO_XTAL = 9'h1FF;

    // Divide by 1000 through a reciprocal, exact for dividends below 2^24
    localparam int               PROD_W      = 47;
    localparam logic [23:0]      RECIP_M     = 24'd8589935;
    localparam int               RECIP_SHIFT = 33;
    localparam int               CVAL_W      = 14;
    localparam logic [1:0]       CUTOFF_MUL  = 2'd3;

    localparam int BAND_COUNT   = 7;
    localparam int CUTOFF_COUNT = 32;
    localparam int CUTOFF_IDX_W = 5;

    localparam logic [VCO_W-1:0] BAND_UPPER [BAND_COUNT] = '{
        26'd2472000, 26'd2700000, 26'd3021000, 26'd3387000,
        26'd3845000, 26'd4394000, 26'd4760000
    };
    localparam logic [2:0] BAND_PUMP [BAND_COUNT] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7
    };
    localparam logic [CVAL_W-1:0] CUTOFF_MHZ [CUTOFF_COUNT] = '{
        14'd6796, 14'd5828, 14'd4778, 14'd4118, 14'd3513, 14'd3136, 14'd2794, 14'd2562,
        14'd2331, 14'd2169, 14'd2006, 14'd1890, 14'd1771, 14'd1680, 14'd1586, 14'd1514,
        14'd1433, 14'd1374, 14'd1310, 14'd1262, 14'd1208, 14'd1167, 14'd1122, 14'd1087,
        14'd1049, 14'd1018, 14'd983,  14'd956,  14'd926,  14'd902,  14'd875,  14'd854
    };

    typedef struct packed {
        logic [1:0]              pdiv_code;
        logic [2:0]              pump;
        logic [CUTOFF_IDX_W-1:0] cutoff;
        logic                    over;
        logic                    clamped;
    } side_t;

endpackage
`default_nettype wire

@@ rtl/fnpll_front.sv @@
// Front stages: post-divider select, VCO scaling, pump band and cutoff lookup.
`default_nettype none
module fnpll_front (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [fnpll_pkg::TARGET_W-1:0]    in_target,
    input  wire                               ref_doubler,
    input  wire  [fnpll_pkg::LIMIT_W-1:0]     limit_16,
    input  wire  [fnpll_pkg::LIMIT_W-1:0]     limit_8,
    input  wire  [fnpll_pkg::LIMIT_W-1:0]     limit_4,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [fnpll_pkg::SCALED_W-1:0]    out_scaled,
    output fnpll_pkg::side_t                  out_side
);

    logic                             v1_reg, v2_reg;
    logic                             rdy1, rdy2;
    logic [fnpll_pkg::TARGET_W-1:0]   target_reg;
    logic [1:0]                       code_reg, code_next;
    logic [fnpll_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [fnpll_pkg::SCALED_W-1:0]   scaled_reg, scaled_next;
    fnpll_pkg::side_t                 side_reg, side_next;
    logic [23:0]                      triple;
    logic [47:0]                      prod_full;
    logic [fnpll_pkg::VCO_W-1:0]      vco;
    logic [fnpll_pkg::CVAL_W-1:0]     cval;
    logic [5:0]                       count;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: threshold compare and reciprocal multiply for 3*target/1000
    always_comb begin
        if (in_target <= limit_16)     code_next = fnpll_pkg::PDIV_P16;
        else if (in_target <= limit_8) code_next = fnpll_pkg::PDIV_P8;
        else if (in_target <= limit_4) code_next = fnpll_pkg::PDIV_P4;
        else                           code_next = fnpll_pkg::PDIV_P2;
        triple    = {2'b00, in_target} * {22'd0, fnpll_pkg::CUTOFF_MUL};
        prod_full = triple * fnpll_pkg::RECIP_M;
        prod_next = prod_full[fnpll_pkg::PROD_W-1:0];
    end

    // Stage 2: VCO, band search, cutoff search
    always_comb begin
        vco = ({4'b0000, target_reg} << code_reg) << 1;
        scaled_next = {1'b0, vco} << ref_doubler;
        side_next.pdiv_code = code_reg;
        side_next.pump      = fnpll_pkg::BAND_PUMP[fnpll_pkg::BAND_COUNT-1];
        side_next.over      = 1'b1;
        for (int i = fnpll_pkg::BAND_COUNT - 1; i >= 0; i--) begin
            if (vco <= fnpll_pkg::BAND_UPPER[i]) begin
                side_next.pump = fnpll_pkg::BAND_PUMP[i];
                side_next.over = 1'b0;
            end
        end
        cval  = prod_reg[fnpll_pkg::PROD_W-1:fnpll_pkg::RECIP_SHIFT];
        count = '0;
        for (int i = 0; i < fnpll_pkg::CUTOFF_COUNT; i++) begin
            count = count + {5'd0, (cval <= fnpll_pkg::CUTOFF_MHZ[i])};
        end
        if (count == 6'd0) begin
            side_next.cutoff  = '0;
            side_next.clamped = 1'b1;
        end else if (count == 6'd32) begin
            side_next.cutoff  = '1;
            side_next.clamped = 1'b1;
        end else begin
            side_next.cutoff  = 5'(count - 6'd1);
            side_next.clamped = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
        if (rdy1 && in_valid) begin
            target_reg <= in_target;
            code_reg   <= code_next;
            prod_reg   <= prod_next;
        end
        if (rdy2 && v1_reg) begin
            scaled_reg <= scaled_next;
            side_reg   <= side_next;
        end
    end

    assign out_valid  = v2_reg;
    assign out_scaled = scaled_reg;
    assign out_side   = side_reg;

endmodule
`default_nettype wire

@@ rtl/fnpll_div.sv @@
// Pipelined restoring divider, several quotient bits per stage, side data carried along.
`default_nettype none
module fnpll_div (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [fnpll_pkg::DIVD_W-1:0]      in_dividend,
    input  wire  [fnpll_pkg::XTAL_W-1:0]      divisor,
    input  wire  fnpll_pkg::side_t            in_side,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [fnpll_pkg::DIVD_W-1:0]      out_quotient,
    output fnpll_pkg::side_t                  out_side
);

    localparam int NS = fnpll_pkg::DIV_STAGES;
    localparam int DW = fnpll_pkg::DIVD_W;
    localparam int RW = fnpll_pkg::REM_W;

    logic [NS-1:0]    v_reg;
    logic [NS:0]      rdy;
    logic [RW-1:0]    rem_reg [NS];
    logic [DW-1:0]    dvd_reg [NS];
    logic [DW-1:0]    quo_reg [NS];
    fnpll_pkg::side_t side_reg [NS];
    logic [RW-1:0]    dsr;

    assign dsr          = {1'b0, divisor};
    assign rdy[NS]      = out_ready;
    assign in_ready     = rdy[0];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic             v_in;
        logic [RW-1:0]    rem_in, rem_next, t_c;
        logic [DW-1:0]    dvd_in, dvd_next, quo_in, quo_next;
        fnpll_pkg::side_t side_in;

        if (g == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign dvd_in  = in_dividend;
            assign quo_in  = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign dvd_in  = dvd_reg[g-1];
            assign quo_in  = quo_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        assign rdy[g] = !v_reg[g] || rdy[g+1];

        always_comb begin
            rem_next = rem_in;
            dvd_next = dvd_in;
            quo_next = quo_in;
            t_c      = '0;
            for (int k = 0; k < fnpll_pkg::DIV_STEP; k++) begin
                t_c      = {rem_next[RW-2:0], dvd_next[DW-1]};
                dvd_next = {dvd_next[DW-2:0], 1'b0};
                if (t_c >= dsr) begin
                    rem_next = t_c - dsr;
                    quo_next = {quo_next[DW-2:0], 1'b1};
                end else begin
                    rem_next = t_c;
                    quo_next = {quo_next[DW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (rdy[g]) begin
                v_reg[g] <= v_in;
            end
            if (rdy[g] && v_in) begin
                rem_reg[g]  <= rem_next;
                dvd_reg[g]  <= dvd_next;
                quo_reg[g]  <= quo_next;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid    = v_reg[NS-1];
    assign out_quotient = quo_reg[NS-1];
    assign out_side     = side_reg[NS-1];

endmodule
`default_nettype wire

@@ rtl/frac_n_pll_setting_calc.sv @@
// The pipeline holds 2 front stages plus DIV_STAGES divider stages.
// One request per cycle unless stalled; the divider retires 8 quotient bits per stage.
// Any stage holds under back-pressure and empty stages fill, so nothing is lost or repeated.
// Reset (synchronous, aresetn low) clears all valid bits and loads the default registers.
`default_nettype none
module frac_n_pll_setting_calc (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire  [fnpll_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [fnpll_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [fnpll_pkg::TARGET_W-1:0]     s_target_khz,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [1:0]                         m_pdiv_code,
    output logic [fnpll_pkg::NINT_W-1:0]       m_n_integer,
    output logic [fnpll_pkg::NFRAC_W-1:0]      m_n_fraction,
    output logic [2:0]                         m_pump_current,
    output logic [fnpll_pkg::CUTOFF_IDX_W-1:0] m_cutoff_index,
    output logic                               m_vco_over_band,
    output logic                               m_cutoff_clamped
);

    logic [fnpll_pkg::XTAL_W-1:0]   xtal_reg;
    logic                           doubler_reg;
    logic [fnpll_pkg::LIMIT_W-1:0]  limit16_reg, limit8_reg, limit4_reg;
    logic                           mid_valid, mid_ready;
    logic [fnpll_pkg::SCALED_W-1:0] mid_scaled;
    fnpll_pkg::side_t               mid_side, out_side;
    logic [fnpll_pkg::DIVD_W-1:0]   dividend, quotient;
    logic [fnpll_pkg::NFRAC_W-1:0]  frac_bits;
    logic                           xtal_zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xtal_reg    <= fnpll_pkg::XTAL_RESET;
            doubler_reg <= fnpll_pkg::DOUBLER_RESET;
            limit16_reg <= fnpll_pkg::LIMIT_16_RESET;
            limit8_reg  <= fnpll_pkg::LIMIT_8_RESET;
            limit4_reg  <= fnpll_pkg::LIMIT_4_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fnpll_pkg::REG_XTAL_KHZ:   xtal_reg    <= cfg_wdata[fnpll_pkg::XTAL_W-1:0];
                fnpll_pkg::REG_REF_DOUBLE: doubler_reg <= cfg_wdata[0];
                fnpll_pkg::REG_LIMIT_16:   limit16_reg <= cfg_wdata;
                fnpll_pkg::REG_LIMIT_8:    limit8_reg  <= cfg_wdata;
                fnpll_pkg::REG_LIMIT_4:    limit4_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    fnpll_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_target   (s_target_khz),
        .ref_doubler (doubler_reg),
        .limit_16    (limit16_reg),
        .limit_8     (limit8_reg),
        .limit_4     (limit4_reg),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .out_scaled  (mid_scaled),
        .out_side    (mid_side)
    );

    // Append the fraction zeros so one long division yields N and F together
    assign dividend = fnpll_pkg::DIVD_W'({mid_scaled, {fnpll_pkg::FRAC_BITS{1'b0}}});

    fnpll_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (mid_valid),
        .in_ready     (mid_ready),
        .in_dividend  (dividend),
        .divisor      (xtal_reg),
        .in_side      (mid_side),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_quotient (quotient),
        .out_side     (out_side)
    );

    if (fnpll_pkg::FRAC_BITS >= fnpll_pkg::NFRAC_W) begin : g_frac_wide
        assign frac_bits = quotient[fnpll_pkg::NFRAC_W-1:0];
    end else begin : g_frac_narrow
        assign frac_bits = fnpll_pkg::NFRAC_W'(quotient[fnpll_pkg::FRAC_BITS-1:0]);
    end

    assign xtal_zero        = (xtal_reg == '0);
    assign m_n_integer      = xtal_zero ? fnpll_pkg::N_ZERO_XTAL
                                        : quotient[fnpll_pkg::FRAC_BITS +: fnpll_pkg::NINT_W];
    assign m_n_fraction     = xtal_zero ? '0 : frac_bits;
    assign m_pdiv_code      = out_side.pdiv_code;
    assign m_pump_current   = out_side.pump;
    assign m_cutoff_index   = out_side.cutoff;
    assign m_vco_over_band  = out_side.over;
    assign m_cutoff_clamped = out_side.clamped;

    a_full_only_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input blocked while output not stalled");

    a_over_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_vco_over_band) |-> (m_pump_current == 3'd7))
        else $error("pump code not saturated above top band");

    a_clamp_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_cutoff_clamped) |-> (m_cutoff_index == '0 || m_cutoff_index == '1))
        else $error("clamped cutoff not at a table edge");

endmodule
`default_nettype wire

@@ dv/frac_n_pll_setting_calc_checker.sv @@
// Checker for the PLL setting calculator: predicts settings per request and compares results.
`timescale 1ns / 100ps
module frac_n_pll_setting_calc_checker
    import fnpll_pkg::*;
(
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_we,
    input  wire  [CFG_IDX_W-1:0]     cfg_index,
    input  wire  [CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                      s_valid,
    input  wire                      s_ready,
    input  wire  [TARGET_W-1:0]      s_target_khz,
    input  wire                      m_valid,
    input  wire                      m_ready,
    input  wire  [1:0]               m_pdiv_code,
    input  wire  [NINT_W-1:0]        m_n_integer,
    input  wire  [NFRAC_W-1:0]       m_n_fraction,
    input  wire  [2:0]               m_pump_current,
    input  wire  [CUTOFF_IDX_W-1:0]  m_cutoff_index,
    input  wire                      m_vco_over_band,
    input  wire                      m_cutoff_clamped,
    output int                       fail_count,
    output int                       pending_count,
    output int                       setting_count
);

    typedef struct packed {
        logic [1:0]              pdiv;
        logic [NINT_W-1:0]       nint;
        logic [NFRAC_W-1:0]      nfrac;
        logic [2:0]              pump;
        logic [CUTOFF_IDX_W-1:0] cutoff;
        logic                    over;
        logic                    clamped;
    } pll_setting_t;

    pll_setting_t expected_settings[$];

    logic [XTAL_W-1:0]  xtal;
    logic               doubler;
    logic [LIMIT_W-1:0] lim16, lim8, lim4;

    function automatic pll_setting_t calc_setting(logic [TARGET_W-1:0] target);
        pll_setting_t r;
        logic [63:0] vco, scaled, cval;
        int cnt;
        if (target <= lim16)      r.pdiv = PDIV_P16;
        else if (target <= lim8)  r.pdiv = PDIV_P8;
        else if (target <= lim4)  r.pdiv = PDIV_P4;
        else                      r.pdiv = PDIV_P2;
        vco = 64'(target) << (r.pdiv + 1);
        scaled = vco << doubler;
        if (xtal == 0) begin
            r.nint = N_ZERO_XTAL;
            r.nfrac = '0;
        end else begin
            r.nint = NINT_W'(scaled / xtal);
            r.nfrac = NFRAC_W'(((scaled % xtal) << FRAC_BITS) / xtal);
        end
        r.over = 1'b1;
        r.pump = BAND_PUMP[BAND_COUNT-1];
        for (int b = BAND_COUNT - 1; b >= 0; b--) begin
            if (vco <= BAND_UPPER[b]) begin
                r.pump = BAND_PUMP[b];
                r.over = 1'b0;
            end
        end
        cval = (64'd3 * target) / 1000;
        cnt = 0;
        while (cnt < CUTOFF_COUNT && cval <= CUTOFF_MHZ[cnt]) cnt++;
        r.clamped = (cnt == 0) || (cnt == CUTOFF_COUNT);
        if (cnt == 0) r.cutoff = '0;
        else r.cutoff = CUTOFF_IDX_W'(cnt - 1);
        return r;
    endfunction

    task automatic compare(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        pll_setting_t e;
        if (!aresetn) begin
            xtal <= XTAL_RESET;
            doubler <= DOUBLER_RESET;
            lim16 <= LIMIT_16_RESET;
            lim8 <= LIMIT_8_RESET;
            lim4 <= LIMIT_4_RESET;
            fail_count <= 0;
            setting_count <= 0;
            expected_settings.delete();
        end else begin
            if (s_valid && s_ready) expected_settings.push_back(calc_setting(s_target_khz));
            if (m_valid && m_ready) begin
                setting_count <= setting_count + 1;
                if (expected_settings.size() == 0) begin
                    $error("result with no request pending");
                    fail_count++;
                end else begin
                    e = expected_settings.pop_front();
                    compare("pdiv_code", e.pdiv, m_pdiv_code);
                    compare("n_integer", e.nint, m_n_integer);
                    compare("n_fraction", e.nfrac, m_n_fraction);
                    compare("pump_current", e.pump, m_pump_current);
                    compare("cutoff_index", e.cutoff, m_cutoff_index);
                    compare("vco_over_band", e.over, m_vco_over_band);
                    compare("cutoff_clamped", e.clamped, m_cutoff_clamped);
                end
            end
            // config takes effect for requests after the write edge
            if (cfg_we) begin
                case (cfg_index)
                    REG_XTAL_KHZ:   xtal <= cfg_wdata[XTAL_W-1:0];
                    REG_REF_DOUBLE: doubler <= cfg_wdata[0];
                    REG_LIMIT_16:   lim16 <= cfg_wdata;
                    REG_LIMIT_8:    lim8 <= cfg_wdata;
                    REG_LIMIT_4:    lim4 <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending_count = expected_settings.size();
    end

endmodule

@@ dv/frac_n_pll_setting_calc_tb.sv @@
// Testbench top for the PLL setting calculator: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module frac_n_pll_setting_calc_tb;
    import fnpll_pkg::*;

    logic aclk, aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_valid, s_ready, m_valid, m_ready;
    logic [TARGET_W-1:0] s_target_khz;
    logic [1:0] m_pdiv_code;
    logic [NINT_W-1:0] m_n_integer;
    logic [NFRAC_W-1:0] m_n_fraction;
    logic [2:0] m_pump_current;
    logic [CUTOFF_IDX_W-1:0] m_cutoff_index;
    logic m_vco_over_band, m_cutoff_clamped;
    int fail_count, pending_count, setting_count;
    int request_count;
    bit stim_done;

    frac_n_pll_setting_calc u_dut (.*);

    frac_n_pll_setting_calc_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("frac_n_pll_setting_calc_tb: FAIL");
        $finish;
    end

    // receiver: random stall before each result
    initial begin
        int gap;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (stim_done && pending_count == 0) m_ready <= 1'b0;
            else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                m_ready <= 1'b1;
                do @(posedge aclk); while (!m_valid);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // valid stays up after acceptance until the next request or a drain drops it
    task automatic send_request(logic [TARGET_W-1:0] target, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_target_khz <= target;
        do @(posedge aclk); while (!s_ready);
        request_count++;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic logic [TARGET_W-1:0] rand_target();
        case ($urandom_range(0, 4))
            0: return TARGET_W'($urandom_range(0, 2500000));
            1: return TARGET_W'($urandom_range(200000, 1400000));
            2: return TARGET_W'($urandom);
            3: return TARGET_W'($urandom_range(0, 400000));
            default: return TARGET_W'($urandom_range(2000000, 4194303));
        endcase
    endfunction

    initial begin
        logic [TARGET_W-1:0] directed[$];
        int gap;
        aresetn = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 0;
        s_target_khz = '0;
        stim_done = 0;
        request_count = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // field extremes, threshold edges, band and cutoff clamps
        directed = '{0, 1, 299000, 299001, 596000, 596001, 1191000, 1191001,
                     2500000, 4194303, 2265333, 284000, 283999, 2000000, 1000,
                     154500, 618000, 2381000, 1190000, 309000, 2097152, 1398101};
        foreach (directed[i]) send_request(directed[i], i % 3);
        drain();

        // zero crystal, no doubler, inverted thresholds
        write_reg(REG_XTAL_KHZ, 0);
        write_reg(REG_REF_DOUBLE, 0);
        write_reg(REG_LIMIT_16, 2500000);
        write_reg(REG_LIMIT_8, 0);
        write_reg(REG_LIMIT_4, 22'h3FFFFF);
        send_request(1234567, 0);
        send_request(4194303, 1);
        send_request(0, 0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_XTAL_KHZ, 16000); write_reg(REG_REF_DOUBLE, 1);
                    write_reg(REG_LIMIT_16, 0); write_reg(REG_LIMIT_8, 0);
                    write_reg(REG_LIMIT_4, 0);
                end
                1: begin
                    write_reg(REG_XTAL_KHZ, 60000); write_reg(REG_REF_DOUBLE, 0);
                    write_reg(REG_LIMIT_16, 2500000); write_reg(REG_LIMIT_8, 2500000);
                    write_reg(REG_LIMIT_4, 2500000);
                end
                2: begin
                    write_reg(REG_XTAL_KHZ, 16'hFFFF); write_reg(REG_REF_DOUBLE, 1);
                    write_reg(REG_LIMIT_16, 22'h3FFFFF); write_reg(REG_LIMIT_8, 22'h2AAAAA);
                    write_reg(REG_LIMIT_4, 22'h155555);
                end
                3: begin
                    write_reg(REG_XTAL_KHZ, 1); write_reg(REG_LIMIT_16, 22'h155555);
                    write_reg(REG_LIMIT_8, 22'h2AAAAA);
                end
                default: begin
                    write_reg(REG_XTAL_KHZ, $urandom_range(16000, 60000));
                    write_reg(REG_REF_DOUBLE, $urandom_range(0, 1));
                    write_reg(REG_LIMIT_16, $urandom_range(0, 800000));
                    write_reg(REG_LIMIT_8, $urandom_range(300000, 1500000));
                    write_reg(REG_LIMIT_4, $urandom_range(600000, 2500000));
                end
            endcase
            for (int k = 0; k < 180; k++) begin
                gap = ((k / 30) % 2 == 0) ? 0 : $urandom_range(0, 18);
                send_request(rand_target(), gap);
            end
            drain();
        end

        stim_done = 1;
        drain();
        $display("Covered %0d requests, %0d results, register sweep incl. zero crystal.",
                 request_count, setting_count);
        if (fail_count == 0) $display("frac_n_pll_setting_calc_tb: PASS");
        else $display("frac_n_pll_setting_calc_tb: FAIL");
        $finish;
    end

endmodule
